>>> hw/rtl/sgr_pkg.sv
// shared types and character constants for the sgr escape sequence parser
package sgr_pkg;

	// sequence bytes of interest
	localparam logic [7:0] CH_SEMI     = 8'h3B;
	localparam logic [7:0] CH_M        = 8'h6D;
	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_0        = 8'h30;
	localparam logic [7:0] CH_1        = 8'h31;
	localparam logic [7:0] CH_2        = 8'h32;
	localparam logic [7:0] CH_3        = 8'h33;
	localparam logic [7:0] CH_4        = 8'h34;
	localparam logic [7:0] CH_5        = 8'h35;
	localparam logic [7:0] CH_7        = 8'h37;
	localparam logic [7:0] CH_8        = 8'h38;
	localparam logic [7:0] CH_9        = 8'h39;

	// number accumulator saturation
	localparam logic [8:0]  NUM_SAT  = 9'd256;
	localparam logic [11:0] BYTE_MAX = 12'd255;

	typedef enum logic [1:0] {
		KIND_SGR     = 2'd0,
		KIND_UNKNOWN = 2'd1,
		KIND_INVALID = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE  = 3'd0,
		ERR_INDEX = 3'd1,
		ERR_RED   = 3'd2,
		ERR_GREEN = 3'd3,
		ERR_BLUE  = 3'd4,
		ERR_PARSE = 3'd5
	} err_t;

	// which parameter of a color selection is expected next
	typedef enum logic [2:0] {
		PH_TOP   = 3'd0,
		PH_FMT   = 3'd1,
		PH_IDX   = 3'd2,
		PH_RED   = 3'd3,
		PH_GREEN = 3'd4,
		PH_BLUE  = 3'd5
	} phase_t;

	typedef struct packed {
		logic        rst;
		logic        bold;
		logic        fg_present;
		logic        fg_true;
		logic [23:0] fg;
		logic        bg_present;
		logic        bg_true;
		logic [23:0] bg;
	} attr_t;

	// parser state that returns to zero after each sequence
	typedef struct packed {
		phase_t      phase;
		logic [7:0]  c0;
		logic [7:0]  c1;
		logic [1:0]  plen;
		logic [8:0]  nval;
		logic        digits;
		logic        closed;
		logic        tgt_bg;
		logic [7:0]  red;
		logic [7:0]  green;
		logic        red_over;
		logic        green_over;
		err_t        err;
		attr_t       attr;
	} pst_t;

	localparam pst_t PST_RESET = pst_t'('0);

	typedef struct packed {
		kind_t kind;
		err_t  err;
		attr_t attr;
	} res_t;

	// result handoff from the decoder to the output register
	typedef struct packed {
		logic load;
		res_t res;
	} res_load_t;

endpackage

>>> hw/rtl/sgr_in_stage.sv
// input register stage for sequence bytes
module sgr_in_stage import sgr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_byte,
	input  logic       final_byte,
	input  logic       step,
	output logic       valid_s1,
	output logic [7:0] char_s1,
	output logic       final_s1
);

	logic accept;

	// take a new item when empty or when the held one moves on
	assign in_ready = !valid_s1 || step;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			char_s1  <= char_byte;
			final_s1 <= final_byte;
		end
	end

endmodule

>>> hw/rtl/sgr_decode.sv
// parser state registers and per-byte decode logic
module sgr_decode import sgr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       valid_s1,
	input  logic [7:0] char_s1,
	input  logic       final_s1,
	input  logic       out_free,
	output logic       step,
	output res_load_t  rl
);

	logic at_start_q, nxt_at_start;
	logic bracket_q, nxt_bracket;
	pst_t st_q, nxt_st;
	pst_t fin1, fin2;
	res_t res;

	// store a color into the current target
	function automatic pst_t put_color(input pst_t s, input logic tru, input logic [23:0] c);
		pst_t r;
		r = s;
		if (s.tgt_bg) begin
			r.attr.bg_present = 1'b1;
			r.attr.bg_true    = tru;
			r.attr.bg         = c;
		end else begin
			r.attr.fg_present = 1'b1;
			r.attr.fg_true    = tru;
			r.attr.fg         = c;
		end
		return r;
	endfunction

	// append one byte to the current parameter
	function automatic pst_t add_byte(input pst_t s, input logic [7:0] b);
		pst_t r;
		logic [11:0] v;
		r = s;
		v = ({3'd0, s.nval} * 12'd10) + {8'd0, b[3:0]};
		if (s.plen == 2'd0) begin
			r.c0 = b;
		end else if (s.plen == 2'd1) begin
			r.c1 = b;
		end
		if (s.plen != 2'd3) begin
			r.plen = s.plen + 2'd1;
		end
		if (!s.closed) begin
			if (b >= CH_0 && b <= CH_9) begin
				r.nval   = (v > BYTE_MAX) ? NUM_SAT : v[8:0];
				r.digits = 1'b1;
			end else begin
				r.closed = 1'b1;
			end
		end
		return r;
	endfunction

	// close the current parameter and act on it
	function automatic pst_t finish_param(input pst_t s);
		pst_t r;
		logic over;
		logic [7:0] v8;
		r = s;
		over = s.nval[8];
		v8 = s.nval[7:0];
		unique case (s.phase)
			PH_TOP: begin
				if (s.plen == 2'd1 && s.c0 == CH_0) begin
					r.attr.rst = 1'b1;
				end else if (s.plen == 2'd1 && s.c0 == CH_1) begin
					r.attr.bold = 1'b1;
				end else if (s.plen != 2'd0 && (s.c0 == CH_3 || s.c0 == CH_4)) begin
					r.tgt_bg = (s.c0 == CH_4);
					if (s.plen >= 2'd2 && s.c1 >= CH_0 && s.c1 <= CH_7) begin
						r = put_color(r, 1'b0, {16'd0, 8'(s.c1 - CH_0)});
					end else if (s.plen >= 2'd2 && s.c1 == CH_8) begin
						r.phase = PH_FMT;
					end else begin
						r = put_color(r, 1'b0, 24'd0);
					end
				end
			end
			PH_FMT: begin
				if (s.plen == 2'd1 && s.c0 == CH_5) begin
					r.phase = PH_IDX;
				end else if (s.plen == 2'd1 && s.c0 == CH_2) begin
					r.phase = PH_RED;
				end else begin
					r = put_color(r, 1'b0, 24'd0);
					r.phase = PH_TOP;
				end
			end
			PH_IDX: begin
				if (!s.digits || over) begin
					r.err = ERR_INDEX;
				end else begin
					r = put_color(r, 1'b0, {16'd0, v8});
				end
				r.phase = PH_TOP;
			end
			PH_RED: begin
				if (!s.digits) begin
					r.err   = ERR_PARSE;
					r.phase = PH_TOP;
				end else begin
					r.red        = v8;
					r.green      = 8'd0;
					r.red_over   = over;
					r.green_over = 1'b0;
					r.phase      = PH_GREEN;
				end
			end
			PH_GREEN: begin
				if (!s.digits) begin
					r.err   = ERR_PARSE;
					r.phase = PH_TOP;
				end else begin
					r.green      = v8;
					r.green_over = s.green_over || over;
					r.phase      = PH_BLUE;
				end
			end
			PH_BLUE: begin
				if (!s.digits) begin
					r.err = ERR_PARSE;
				end else if (s.red_over) begin
					r.err = ERR_RED;
				end else if (s.green_over) begin
					r.err = ERR_GREEN;
				end else if (over) begin
					r.err = ERR_BLUE;
				end else begin
					r = put_color(r, 1'b1, {s.red, s.green, v8});
				end
				r.phase = PH_TOP;
			end
			default: begin
				r.phase = PH_TOP;
			end
		endcase
		r.c0     = 8'd0;
		r.c1     = 8'd0;
		r.plen   = 2'd0;
		r.nval   = 9'd0;
		r.digits = 1'b0;
		r.closed = 1'b0;
		return r;
	endfunction

	// the held item moves on unless it is a terminator and the result register is not free
	assign step = valid_s1 && (!final_s1 || out_free);

	// terminator: close the last parameter, then at most one missing one
	always_comb begin
		fin1 = (st_q.err == ERR_NONE) ? finish_param(st_q) : st_q;
		fin2 = (fin1.phase != PH_TOP && fin1.err == ERR_NONE) ? finish_param(fin1) : fin1;
	end

	// next state and result
	always_comb begin
		nxt_at_start = at_start_q;
		nxt_bracket  = bracket_q;
		nxt_st       = st_q;
		res          = res_t'('0);
		res.kind     = KIND_UNKNOWN;
		if (at_start_q) begin
			nxt_at_start = 1'b0;
			nxt_bracket  = (char_s1 == CH_LBRACKET);
		end else if (!final_s1) begin
			if (bracket_q && st_q.err == ERR_NONE) begin
				nxt_st = (char_s1 == CH_SEMI) ? finish_param(st_q) : add_byte(st_q, char_s1);
			end
		end else if (bracket_q && char_s1 == CH_M) begin
			if (fin2.err != ERR_NONE) begin
				res.kind = KIND_INVALID;
				res.err  = fin2.err;
			end else begin
				res.kind = KIND_SGR;
				res.attr = fin2.attr;
			end
		end
		if (final_s1) begin
			nxt_at_start = 1'b1;
			nxt_bracket  = 1'b0;
			nxt_st       = PST_RESET;
		end
	end

	assign rl.load = step && final_s1;
	assign rl.res  = res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_start_q <= 1'b1;
			bracket_q  <= 1'b0;
			st_q       <= PST_RESET;
		end else if (step) begin
			at_start_q <= nxt_at_start;
			bracket_q  <= nxt_bracket;
			st_q       <= nxt_st;
		end
	end

endmodule

>>> hw/rtl/sgr_out_stage.sv
// result register with valid and ready toward the consumer
module sgr_out_stage import sgr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  res_load_t rl,
	output logic      out_free,
	output logic      out_valid,
	input  logic      out_ready,
	output res_t      res_q
);

	// register may be refilled when empty or being drained
	assign out_free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (rl.load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (rl.load) begin
			res_q <= rl.res;
		end
	end

endmodule

>>> hw/rtl/sgr_escape_parser.sv
// top level of the sgr escape sequence parser
// a terminator goes into the input register, then its result into the result register
// throughput: one byte per cycle; the input register and result register each decouple a side
// a byte stalls only when it is a terminator and the result register is still held
// reset (arst_n low) clears both handshake stages and returns the parser to sequence start
module sgr_escape_parser import sgr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_byte,
	input  logic        final_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  seq_kind,
	output logic [2:0]  error_code,
	output logic        reset_seen,
	output logic        bold_seen,
	output logic        fg_present,
	output logic        fg_is_truecolor,
	output logic [23:0] fg_color,
	output logic        bg_present,
	output logic        bg_is_truecolor,
	output logic [23:0] bg_color
);

	logic       step;
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       final_s1;
	logic       out_free;
	res_load_t  rl;
	res_t       res_q;

	sgr_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.char_byte  (char_byte),
		.final_byte (final_byte),
		.step       (step),
		.valid_s1   (valid_s1),
		.char_s1    (char_s1),
		.final_s1   (final_s1)
	);

	sgr_decode u_dec (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.char_s1  (char_s1),
		.final_s1 (final_s1),
		.out_free (out_free),
		.step     (step),
		.rl       (rl)
	);

	sgr_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.rl        (rl),
		.out_free  (out_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_q     (res_q)
	);

	// unpack the result fields
	assign seq_kind        = res_q.kind;
	assign error_code      = res_q.err;
	assign reset_seen      = res_q.attr.rst;
	assign bold_seen       = res_q.attr.bold;
	assign fg_present      = res_q.attr.fg_present;
	assign fg_is_truecolor = res_q.attr.fg_true;
	assign fg_color        = res_q.attr.fg;
	assign bg_present      = res_q.attr.bg_present;
	assign bg_is_truecolor = res_q.attr.bg_true;
	assign bg_color        = res_q.attr.bg;

endmodule

>>> tb/tb_top.sv
// self-checking testbench for the sgr escape sequence parser
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import sgr_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	// block ports
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  char_byte = 8'h00;
	logic        final_byte = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  seq_kind;
	logic [2:0]  error_code;
	logic        reset_seen;
	logic        bold_seen;
	logic        fg_present;
	logic        fg_is_truecolor;
	logic [23:0] fg_color;
	logic        bg_present;
	logic        bg_is_truecolor;
	logic [23:0] bg_color;

	// run bookkeeping
	int   cycle_count = 0;
	int   fail_count = 0;
	int   bytes_sent = 0;
	int   send_idle_pct = 10;
	int   recv_idle_pct = 66;
	res_t sgr_results_due[$];
	res_t due_res;
	logic [7:0] seq_bytes[$];

	// predicted parser state, back to its cleared value after every terminator
	logic       seq_start;
	logic       seq_bracket;
	phase_t     prm_phase;
	logic [7:0] prm_c0;
	logic [7:0] prm_c1;
	logic [1:0] prm_len;
	logic [8:0] prm_num;
	logic       prm_digits;
	logic       prm_closed;
	logic       color_to_bg;
	logic [7:0] rgb_red;
	logic [7:0] rgb_green;
	logic       red_over;
	logic       green_over;
	err_t       seq_err;
	attr_t      seq_attr;

	sgr_escape_parser dut (.*);

	// clock
	always #1 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// result side back-pressure
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
	end

	task automatic report_mismatch(input string msg);
		fail_count++;
		$display("mismatch at cycle %0d: %s", cycle_count, msg);
	endtask

	task automatic check_field(input string what, input logic [23:0] got,
			input logic [23:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h want %0h", what, got, want));
	endtask

	// compare each delivered result with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (sgr_results_due.size() == 0) begin
				report_mismatch("result delivered with nothing due");
			end else begin
				due_res = sgr_results_due.pop_front();
				check_field("seq_kind", seq_kind, due_res.kind);
				check_field("error_code", error_code, due_res.err);
				check_field("reset_seen", reset_seen, due_res.attr.rst);
				check_field("bold_seen", bold_seen, due_res.attr.bold);
				check_field("fg_present", fg_present, due_res.attr.fg_present);
				check_field("fg_is_truecolor", fg_is_truecolor, due_res.attr.fg_true);
				check_field("fg_color", fg_color, due_res.attr.fg);
				check_field("bg_present", bg_present, due_res.attr.bg_present);
				check_field("bg_is_truecolor", bg_is_truecolor, due_res.attr.bg_true);
				check_field("bg_color", bg_color, due_res.attr.bg);
			end
		end
	end

	// predictor: parameter scratch clear
	function automatic void clear_param();
		prm_c0 = 8'h00;
		prm_c1 = 8'h00;
		prm_len = 2'd0;
		prm_num = 9'd0;
		prm_digits = 1'b0;
		prm_closed = 1'b0;
	endfunction

	// predictor: whole sequence clear
	function automatic void clear_sequence();
		seq_start = 1'b1;
		seq_bracket = 1'b0;
		prm_phase = PH_TOP;
		clear_param();
		color_to_bg = 1'b0;
		rgb_red = 8'h00;
		rgb_green = 8'h00;
		red_over = 1'b0;
		green_over = 1'b0;
		seq_err = ERR_NONE;
		seq_attr = '0;
	endfunction

	function automatic void store_color(input logic truecolor, input logic [23:0] color);
		if (color_to_bg) begin
			seq_attr.bg_present = 1'b1;
			seq_attr.bg_true = truecolor;
			seq_attr.bg = color;
		end else begin
			seq_attr.fg_present = 1'b1;
			seq_attr.fg_true = truecolor;
			seq_attr.fg = color;
		end
	endfunction

	// keep the first two characters and the leading digit run
	function automatic void take_param_byte(input logic [7:0] b);
		int unsigned acc;
		if (prm_len == 2'd0)
			prm_c0 = b;
		else if (prm_len == 2'd1)
			prm_c1 = b;
		if (prm_len != 2'd3)
			prm_len = prm_len + 2'd1;
		if (!prm_closed) begin
			if (b >= CH_0 && b <= CH_9) begin
				acc = prm_num * 10 + (b - CH_0);
				prm_num = (acc > 255) ? NUM_SAT : 9'(acc);
				prm_digits = 1'b1;
			end else begin
				prm_closed = 1'b1;
			end
		end
	endfunction

	// act on a finished parameter according to the color selection phase
	function automatic void close_param();
		logic over;
		over = (prm_num > 9'd255);
		case (prm_phase)
			PH_TOP: begin
				if (prm_len == 2'd1 && prm_c0 == CH_0) begin
					seq_attr.rst = 1'b1;
				end else if (prm_len == 2'd1 && prm_c0 == CH_1) begin
					seq_attr.bold = 1'b1;
				end else if (prm_len != 2'd0 && (prm_c0 == CH_3 || prm_c0 == CH_4)) begin
					color_to_bg = (prm_c0 == CH_4);
					if (prm_len >= 2'd2 && prm_c1 >= CH_0 && prm_c1 <= CH_7)
						store_color(1'b0, 24'(prm_c1 - CH_0));
					else if (prm_len >= 2'd2 && prm_c1 == CH_8)
						prm_phase = PH_FMT;
					else
						store_color(1'b0, 24'd0);
				end
			end
			PH_FMT: begin
				if (prm_len == 2'd1 && prm_c0 == CH_5) begin
					prm_phase = PH_IDX;
				end else if (prm_len == 2'd1 && prm_c0 == CH_2) begin
					prm_phase = PH_RED;
				end else begin
					store_color(1'b0, 24'd0);
					prm_phase = PH_TOP;
				end
			end
			PH_IDX: begin
				if (!prm_digits || over)
					seq_err = ERR_INDEX;
				else
					store_color(1'b0, 24'(prm_num[7:0]));
				prm_phase = PH_TOP;
			end
			PH_RED: begin
				if (!prm_digits) begin
					seq_err = ERR_PARSE;
					prm_phase = PH_TOP;
				end else begin
					rgb_red = prm_num[7:0];
					rgb_green = 8'h00;
					red_over = over;
					green_over = 1'b0;
					prm_phase = PH_GREEN;
				end
			end
			PH_GREEN: begin
				if (!prm_digits) begin
					seq_err = ERR_PARSE;
					prm_phase = PH_TOP;
				end else begin
					rgb_green = prm_num[7:0];
					if (over)
						green_over = 1'b1;
					prm_phase = PH_BLUE;
				end
			end
			PH_BLUE: begin
				// parse failure first, then range checks red, green, blue
				if (!prm_digits)
					seq_err = ERR_PARSE;
				else if (red_over)
					seq_err = ERR_RED;
				else if (green_over)
					seq_err = ERR_GREEN;
				else if (over)
					seq_err = ERR_BLUE;
				else
					store_color(1'b1, {rgb_red, rgb_green, prm_num[7:0]});
				prm_phase = PH_TOP;
			end
			default: prm_phase = PH_TOP;
		endcase
		clear_param();
	endfunction

	// predictor: one accepted byte, queues a result on every terminator
	function automatic void decode_sgr_byte(input logic [7:0] b, input logic last);
		res_t r;
		r = '0;
		r.kind = KIND_UNKNOWN;
		r.err = ERR_NONE;
		if (seq_start) begin
			seq_start = 1'b0;
			seq_bracket = (b == CH_LBRACKET);
			if (!last)
				return;
		end else if (!last) begin
			// errors are sticky, later bytes are dropped
			if (seq_bracket && seq_err == ERR_NONE) begin
				if (b == CH_SEMI)
					close_param();
				else
					take_param_byte(b);
			end
			return;
		end else if (seq_bracket && b == CH_M) begin
			// close the last parameter and any color selection left open
			if (seq_err == ERR_NONE)
				close_param();
			while (prm_phase != PH_TOP && seq_err == ERR_NONE)
				close_param();
			if (seq_err != ERR_NONE) begin
				r.kind = KIND_INVALID;
				r.err = seq_err;
			end else begin
				r.kind = KIND_SGR;
				r.attr = seq_attr;
			end
		end
		sgr_results_due.push_back(r);
		clear_sequence();
	endfunction

	// send one item; valid is left high for a following item
	task automatic send_byte(input logic [7:0] value, input logic last);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		char_byte <= value;
		final_byte <= last;
		do @(posedge clk); while (!in_ready);
		decode_sgr_byte(value, last);
		bytes_sent++;
	endtask

	task automatic send_sequence();
		for (int i = 0; i < seq_bytes.size(); i++)
			send_byte(seq_bytes[i], i == seq_bytes.size() - 1);
		seq_bytes.delete();
	endtask

	function automatic void add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			seq_bytes.push_back(s[i]);
	endfunction

	task automatic send_text(input string s);
		seq_bytes.delete();
		add_text(s);
		send_sequence();
	endtask

	// hold the sender off until every result is back
	task automatic wait_for_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sgr_results_due.size() != 0)
			@(posedge clk);
	endtask

	// numeric parameter text, mostly in range, sometimes broken
	function automatic string component_text();
		case ($urandom_range(15, 0))
			0: return "";
			1: return $sformatf("%0d", $urandom_range(999, 256));
			2: return "65536";
			3: return $sformatf("x%0d", $urandom_range(9, 0));
			4: return $sformatf("%0dq", $urandom_range(255, 0));
			5: return $sformatf("00%0d", $urandom_range(9, 0));
			default: return $sformatf("%0d", $urandom_range(255, 0));
		endcase
	endfunction

	function automatic void add_random_param();
		string dir;
		dir = ($urandom_range(1, 0) != 0) ? "4" : "3";
		case ($urandom_range(11, 0))
			0: add_text("0");
			1: add_text("1");
			2: begin
				add_text(dir);
				seq_bytes.push_back(8'($urandom_range(CH_9, CH_0)));
			end
			3: add_text({dir, "8;5;", component_text()});
			4: add_text({dir, "8;2;", component_text(), ";", component_text(), ";",
				component_text()});
			5: begin
				// color selection cut short
				case ($urandom_range(2, 0))
					0: add_text({dir, "8"});
					1: add_text({dir, "8;5"});
					default: add_text({dir, "8;2;", component_text(), ";", component_text()});
				endcase
			end
			6: add_text(component_text());
			7: ;
			8: repeat ($urandom_range(3, 1)) seq_bytes.push_back(8'($urandom_range(255, 0)));
			9: begin
				add_text(dir);
				seq_bytes.push_back(8'($urandom_range(255, 0)));
			end
			10: add_text({dir, "8;", $sformatf("%0d", $urandom_range(9, 0))});
			default: add_text($sformatf("%0d", $urandom_range(99, 2)));
		endcase
	endfunction

	task automatic send_random_sequence();
		int nparams;
		seq_bytes.delete();
		case ($urandom_range(9, 0))
			0: begin
				// random bytes, terminator often m
				repeat ($urandom_range(7, 1)) seq_bytes.push_back(8'($urandom_range(255, 0)));
				seq_bytes.push_back(($urandom_range(1, 0) != 0) ? CH_M : 8'($urandom_range(255, 0)));
			end
			1: seq_bytes.push_back(8'($urandom_range(255, 0)));
			default: begin
				seq_bytes.push_back(CH_LBRACKET);
				nparams = $urandom_range(5, 0);
				for (int i = 0; i < nparams; i++) begin
					if (i != 0)
						seq_bytes.push_back(CH_SEMI);
					add_random_param();
				end
				seq_bytes.push_back(CH_M);
				// broken framing now and then
				if ($urandom_range(9, 0) == 0) begin
					if ($urandom_range(1, 0) != 0)
						seq_bytes[0] = 8'($urandom_range(255, 0));
					else
						seq_bytes[seq_bytes.size() - 1] = 8'($urandom_range(255, 0));
				end
			end
		endcase
		send_sequence();
	endtask

	task automatic test_plain_attributes();
		send_text("[m");
		send_text("[0;1m");
		send_text("[00;;1m");
		send_text("[22;0m");
	endtask

	task automatic test_palette_colors();
		send_text("[31;42m");
		send_text("[37;40;35m");
		send_text("[39;4m");
		send_text("[38;5;0;48;5;255m");
		send_text("[38;3;7m");
		send_text("[48m");
		send_text("[317m");
	endtask

	task automatic test_truecolor();
		send_text("[38;2;255;128;0m");
		send_text("[48;2;0;0;0;38;2;1;2;3m");
		send_text("[38;2;007;12z;255m");
	endtask

	task automatic test_color_errors();
		send_text("[38;5;256m");
		send_text("[48;5m");
		send_text("[38;2;256;300;999m");
		send_text("[38;2;1;300;999m");
		send_text("[38;2;1;2;65536m");
		send_text("[38;2;999;1;xm");
		send_text("[48;2;1;2m");
		send_text("[38;5;x;1m");
	endtask

	task automatic test_foreign_sequences();
		send_text("]0m");
		send_text("[31x");
		send_text("m");
		send_text("[");
		seq_bytes = '{8'hFF, 8'h00, 8'h7F, 8'h80, CH_M};
		send_sequence();
		seq_bytes = '{CH_LBRACKET, 8'hFF, CH_SEMI, 8'h00, 8'h80, CH_SEMI, 8'h7F, CH_M};
		send_sequence();
	endtask

	task automatic test_random_traffic(input int send_pct, input int recv_pct,
			input int byte_budget);
		int first_byte;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		first_byte = bytes_sent;
		while (bytes_sent - first_byte < byte_budget)
			send_random_sequence();
		wait_for_results();
	endtask

	initial begin
		clear_sequence();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_plain_attributes();
		test_palette_colors();
		test_truecolor();
		test_color_errors();
		test_foreign_sequences();
		wait_for_results();
		test_random_traffic(10, 66, 520);
		test_random_traffic(66, 10, 520);
		test_random_traffic(0, 0, 520);
		// allow for late or extra results
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

>>> files.f
hw/rtl/sgr_pkg.sv
hw/rtl/sgr_in_stage.sv
hw/rtl/sgr_decode.sv
hw/rtl/sgr_out_stage.sv
hw/rtl/sgr_escape_parser.sv
tb/tb_top.sv
